/* hdl/baie_pkg.sv */
// Package for the bounded array block: operation and status codes, controller
// states and the command and status structs between controller and datapath.
// No dependencies.
package baie_pkg;

  // Fixed port widths of the operation and result fields.
  localparam int OP_W        = 3;
  localparam int POS_W       = 8;
  localparam int VALUE_W     = 32;
  localparam int NEW_COUNT_W = 8;
  localparam int STATUS_W    = 3;
  localparam int OUT_COUNT_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_ERASE  = 3'd3,
    OP_REMOVE = 3'd4,
    OP_FILL   = 3'd5,
    OP_RESIZE = 3'd6,
    OP_READ   = 3'd7
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_TOO_LARGE = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PREP,
    S_RUN,
    S_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the input transaction
    logic prep;    // check the request and set up the sweep
    logic step;    // advance the sweep by one entry
    logic finish;  // final write, count update and result capture
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;      // no sweep work left
    logic out_free;  // result register can take a new result
  } dp_sts_t;

endpackage

/* hdl/baie_ctrl.sv */
// Controller state machine for the bounded array block.
// Depends on baie_pkg; drives the commands of baie_dp.
module baie_ctrl import baie_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_RUN;
      end
      S_RUN: begin
        if (sts.done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        // Hold here while the previous result still waits to be taken.
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

/* hdl/baie_dp.sv */
// Datapath for the bounded array block: element memory, live count, sweep
// counters and the result register. Depends on baie_pkg; driven by baie_ctrl.
module baie_dp import baie_pkg::*; #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic        [OP_W-1:0]        in_operation,
  input  logic        [POS_W-1:0]       in_position,
  input  logic signed [VALUE_W-1:0]     in_value,
  input  logic        [NEW_COUNT_W-1:0] in_new_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [STATUS_W-1:0]    out_status,
  output logic        [OUT_COUNT_W-1:0] out_count,
  output logic signed [VALUE_W-1:0]     out_read_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int WW = (CW > POS_W) ? CW : POS_W;
  localparam int XW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;

  logic [DATA_WIDTH-1:0] mem [CAPACITY];
  logic [DATA_WIDTH-1:0] mem_q_r;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_wa, mem_ra;
  logic [DATA_WIDTH-1:0] mem_wd;

  op_t                   op_r, op_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [NEW_COUNT_W-1:0] req_r, req_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  status_t               st_r, st_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt;
  logic [CW-1:0]         tgt_r, tgt_nxt;
  logic [CW-1:0]         left_r, left_nxt;
  logic [CW-1:0]         rd_idx_r, rd_idx_nxt;
  logic [CW-1:0]         wr_idx_r, wr_idx_nxt;
  logic                  q_v_r, q_v_nxt;
  logic [VALUE_W-1:0]    rd_word_r, rd_word_nxt;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r, out_status_nxt;
  logic [OUT_COUNT_W-1:0] out_count_r, out_count_nxt;
  logic [VALUE_W-1:0]    out_data_r, out_data_nxt;

  logic signed [XW-1:0]  in_ext, q_ext;
  logic [WW-1:0]         posx, cntx, reqx;
  logic [CW-1:0]         ins_pos, er_pos;
  logic                  full, empty;

  // The stored word is the input value sign-extended or cut to DATA_WIDTH,
  // and a read word is sign-extended or cut back to the port width.
  assign in_ext = XW'(in_value);
  assign q_ext  = XW'(signed'(mem_q_r));

  assign posx    = WW'(pos_r);
  assign cntx    = WW'(cnt_r);
  assign reqx    = WW'(req_r);
  assign ins_pos = (posx > cntx) ? cnt_r : CW'(posx);
  assign er_pos  = (posx >= cntx) ? (cnt_r - CW'(1)) : CW'(posx);
  assign full    = (cnt_r == CW'(CAPACITY));
  assign empty   = (cnt_r == '0);

  assign sts.done     = (left_r == '0) && !q_v_r;
  assign sts.out_free = !out_valid_r || out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_count     = out_count_r;
  assign out_read_data = out_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_ra];
    end
  end

  always_comb begin
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    req_nxt        = req_r;
    val_nxt        = val_r;
    st_nxt         = st_r;
    cnt_nxt        = cnt_r;
    tgt_nxt        = tgt_r;
    left_nxt       = left_r;
    rd_idx_nxt     = rd_idx_r;
    wr_idx_nxt     = wr_idx_r;
    q_v_nxt        = q_v_r;
    rd_word_nxt    = rd_word_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_data_nxt   = out_data_r;
    mem_we         = 1'b0;
    mem_wa         = wr_idx_r[AW-1:0];
    mem_wd         = mem_q_r;
    mem_re         = 1'b0;
    mem_ra         = rd_idx_r[AW-1:0];

    if (cmd.load) begin
      op_nxt  = op_t'(in_operation);
      pos_nxt = in_position;
      req_nxt = in_new_count;
      val_nxt = in_ext[DATA_WIDTH-1:0];
    end

    if (cmd.prep) begin
      st_nxt      = ST_OK;
      tgt_nxt     = cnt_r;
      left_nxt    = '0;
      rd_idx_nxt  = '0;
      wr_idx_nxt  = '0;
      q_v_nxt     = 1'b0;
      rd_word_nxt = '0;
      unique case (op_r)
        OP_PUSH: begin
          if (full) begin
            st_nxt = ST_FULL;
          end
        end
        OP_POP: begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end
        end
        OP_INSERT: begin
          if (full) begin
            st_nxt = ST_FULL;
          end else begin
            // Shift the tail up one place, last entry first.
            tgt_nxt    = ins_pos;
            left_nxt   = cnt_r - ins_pos;
            rd_idx_nxt = cnt_r - CW'(1);
            wr_idx_nxt = cnt_r;
          end
        end
        OP_ERASE: begin
          if (empty) begin
            st_nxt = ST_EMPTY;
          end else begin
            left_nxt   = cnt_r - CW'(1) - er_pos;
            rd_idx_nxt = er_pos + CW'(1);
            wr_idx_nxt = er_pos;
          end
        end
        OP_REMOVE: begin
          left_nxt = cnt_r;
        end
        OP_FILL: begin
          left_nxt = cnt_r;
        end
        OP_RESIZE: begin
          if (reqx > WW'(CAPACITY)) begin
            st_nxt = ST_TOO_LARGE;
          end else begin
            tgt_nxt    = CW'(reqx);
            left_nxt   = (CW'(reqx) > cnt_r) ? (CW'(reqx) - cnt_r) : '0;
            wr_idx_nxt = cnt_r;
          end
        end
        OP_READ: begin
          if (posx >= cntx) begin
            st_nxt = ST_RANGE;
          end else begin
            left_nxt   = CW'(1);
            rd_idx_nxt = CW'(posx);
          end
        end
        default: begin
          st_nxt = ST_OK;
        end
      endcase
    end

    if (cmd.step) begin
      q_v_nxt = 1'b0;
      if (left_r != '0) begin
        left_nxt = left_r - CW'(1);
        case (op_r) inside
          OP_FILL, OP_RESIZE: begin
            mem_we     = 1'b1;
            mem_wa     = wr_idx_r[AW-1:0];
            mem_wd     = (op_r == OP_FILL) ? val_r : '0;
            wr_idx_nxt = wr_idx_r + CW'(1);
          end
          OP_INSERT: begin
            mem_re     = 1'b1;
            rd_idx_nxt = rd_idx_r - CW'(1);
            q_v_nxt    = 1'b1;
          end
          default: begin
            mem_re     = 1'b1;
            rd_idx_nxt = rd_idx_r + CW'(1);
            q_v_nxt    = 1'b1;
          end
        endcase
      end
      // The word read in the previous cycle is written back or captured now.
      if (q_v_r) begin
        case (op_r) inside
          OP_INSERT: begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_idx_r - CW'(1);
          end
          OP_ERASE: begin
            mem_we     = 1'b1;
            wr_idx_nxt = wr_idx_r + CW'(1);
          end
          OP_REMOVE: begin
            if (mem_q_r != val_r) begin
              mem_we     = 1'b1;
              wr_idx_nxt = wr_idx_r + CW'(1);
            end
          end
          OP_READ: begin
            rd_word_nxt = q_ext[VALUE_W-1:0];
          end
          default: begin
            rd_word_nxt = rd_word_r;
          end
        endcase
      end
    end

    if (cmd.finish) begin
      case (op_r) inside
        OP_PUSH, OP_INSERT: begin
          if (st_r == ST_OK) begin
            mem_we  = 1'b1;
            mem_wa  = tgt_r[AW-1:0];
            mem_wd  = val_r;
            cnt_nxt = cnt_r + CW'(1);
          end
        end
        OP_POP, OP_ERASE: begin
          if (st_r == ST_OK) begin
            cnt_nxt = cnt_r - CW'(1);
          end
        end
        OP_REMOVE: begin
          // The write pointer has counted the kept entries.
          cnt_nxt = wr_idx_r;
        end
        OP_RESIZE: begin
          if (st_r == ST_OK) begin
            cnt_nxt = tgt_r;
          end
        end
        default: begin
          cnt_nxt = cnt_r;
        end
      endcase
      out_valid_nxt  = 1'b1;
      out_status_nxt = st_r;
      out_count_nxt  = OUT_COUNT_W'(cnt_nxt);
      out_data_nxt   = rd_word_r;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      left_r      <= '0;
      q_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      q_v_r       <= q_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    req_r        <= req_nxt;
    val_r        <= val_nxt;
    st_r         <= st_nxt;
    tgt_r        <= tgt_nxt;
    rd_idx_r     <= rd_idx_nxt;
    wr_idx_r     <= wr_idx_nxt;
    rd_word_r    <= rd_word_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_data_r   <= out_data_nxt;
  end

endmodule

/* hdl/bounded_array_insert_erase_top.sv */
// Top level of the bounded array block: ordered list of signed words with
// insert, erase, remove, fill, resize and read. Depends on baie_pkg,
// baie_ctrl and baie_dp.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    operation, position, value, new_count
//   out_     output     out_valid / out_ready  status, count, read_data
//
// One transaction is worked at a time. It passes through the controller states
// S_IDLE, S_PREP, S_RUN and S_FINISH; in S_RUN insert and erase shift the tail,
// fill and resize write entries, remove sweeps the whole list and read fetches
// its word. The element memory has one read and one write port and moves one
// entry per cycle. in_ready rises in the cycle the result appears. Reset needs
// no clearing pass. A result waiting on out_ready does not block acceptance of
// the next transaction, but that one completes only after the waiting result
// has been taken.
module bounded_array_insert_erase_top import baie_pkg::*; #(
  parameter int CAPACITY   = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic        [OP_W-1:0]        in_operation,
  input  logic        [POS_W-1:0]       in_position,
  input  logic signed [VALUE_W-1:0]     in_value,
  input  logic        [NEW_COUNT_W-1:0] in_new_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic        [STATUS_W-1:0]    out_status,
  output logic        [OUT_COUNT_W-1:0] out_count,
  output logic signed [VALUE_W-1:0]     out_read_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  baie_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  baie_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_operation  (in_operation),
    .in_position   (in_position),
    .in_value      (in_value),
    .in_new_count  (in_new_count),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_count     (out_count),
    .out_read_data (out_read_data)
  );

endmodule

/* bench/bounded_array_insert_erase_top_tb.sv */
// Testbench for bounded_array_insert_erase_top. It drives list operations and
// predicts each result with a scoreboard that mirrors the list contents.
// Depends on baie_pkg and the RTL of the block.
`timescale 1ns / 100ps

module bounded_array_insert_erase_top_tb import baie_pkg::*; ();

  localparam int CAP            = 128;
  localparam int RANDOM_ITEMS   = 900;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    status_t                   status;
    logic [OUT_COUNT_W-1:0]    count;
    logic signed [VALUE_W-1:0] data;
  } list_result_t;

  // Mirror of the list; every accepted transaction is applied here and the
  // result it must produce is queued.
  class list_scoreboard;
    logic signed [VALUE_W-1:0] cells [CAP];
    int unsigned               live;
    list_result_t              pending [$];
    int                        errors;
    int                        checked;
    int                        op_seen [8];
    int                        status_seen [8];

    function new();
      live    = 0;
      errors  = 0;
      checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_input(logic [OP_W-1:0] op_bits, logic [POS_W-1:0] pos_in,
                             logic signed [VALUE_W-1:0] word,
                             logic [NEW_COUNT_W-1:0] want);
      list_result_t res;
      int unsigned  p;
      int unsigned  k;
      int unsigned  kept;
      res.status = ST_OK;
      res.data   = '0;
      p          = 32'(pos_in);
      op_seen[op_bits]++;
      case (op_t'(op_bits))
        OP_PUSH: begin
          if (live >= CAP) begin
            res.status = ST_FULL;
          end else begin
            cells[live] = word;
            live++;
          end
        end
        OP_POP: begin
          if (live == 0) res.status = ST_EMPTY;
          else live--;
        end
        OP_INSERT: begin
          if (live >= CAP) begin
            res.status = ST_FULL;
          end else begin
            if (p > live) p = live;
            for (k = live; k > p; k--) cells[k] = cells[k-1];
            cells[p] = word;
            live++;
          end
        end
        OP_ERASE: begin
          if (live == 0) begin
            res.status = ST_EMPTY;
          end else begin
            if (p >= live) p = live - 1;
            for (k = p; k + 1 < live; k++) cells[k] = cells[k+1];
            live--;
          end
        end
        OP_REMOVE: begin
          kept = 0;
          for (k = 0; k < live; k++) begin
            if (cells[k] != word) begin
              cells[kept] = cells[k];
              kept++;
            end
          end
          live = kept;
        end
        OP_FILL: begin
          for (k = 0; k < live; k++) cells[k] = word;
        end
        OP_RESIZE: begin
          if (want > CAP) begin
            res.status = ST_TOO_LARGE;
          end else begin
            for (k = live; k < want; k++) cells[k] = '0;
            live = 32'(want);
          end
        end
        OP_READ: begin
          if (p >= live) res.status = ST_RANGE;
          else res.data = cells[p];
        end
      endcase
      res.count = OUT_COUNT_W'(live);
      status_seen[res.status]++;
      pending.push_back(res);
    endfunction

    function void check_result(logic [STATUS_W-1:0] st, logic [OUT_COUNT_W-1:0] cnt,
                               logic signed [VALUE_W-1:0] rd);
      list_result_t want_res;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, status %0d count %0d read_data %0d",
                 $time, st, cnt, rd);
        errors++;
        return;
      end
      want_res = pending.pop_front();
      checked++;
      if (st !== want_res.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d",
                 $time, want_res.status, st);
        errors++;
      end
      if (cnt !== want_res.count) begin
        $display("%0t: count mismatch, expected %0d actual %0d",
                 $time, want_res.count, cnt);
        errors++;
      end
      if (rd !== want_res.data) begin
        $display("%0t: read_data mismatch, expected %0d actual %0d",
                 $time, want_res.data, rd);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic        [OP_W-1:0]        in_operation;
  logic        [POS_W-1:0]       in_position;
  logic signed [VALUE_W-1:0]     in_value;
  logic        [NEW_COUNT_W-1:0] in_new_count;
  logic                          out_valid;
  logic                          out_ready;
  logic        [STATUS_W-1:0]    out_status;
  logic        [OUT_COUNT_W-1:0] out_count;
  logic signed [VALUE_W-1:0]     out_read_data;

  list_scoreboard sb = new();
  bit             idle_on;
  int             quiet_cycles;
  int             stall_left;

  bounded_array_insert_erase_top #(
    .CAPACITY  (CAP),
    .DATA_WIDTH(VALUE_W)
  ) DUT (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_position  (in_position),
    .in_value     (in_value),
    .in_new_count (in_new_count),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_status   (out_status),
    .out_count    (out_count),
    .out_read_data(out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Both channels are observed at the rising edge; inputs only move at the
  // falling edge, so the sampled values are stable.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_input(in_operation, in_position, in_value, in_new_count);
      if (out_valid && out_ready)
        sb.check_result(out_status, out_count, out_read_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("bounded_array_insert_erase_top_tb: errors");
        $finish;
      end
    end
  end

  // Receiver back-pressure in random bursts.
  initial begin
    out_ready  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (!idle_on) begin
        out_ready  = 1'b1;
        stall_left = 0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 5) == 0) begin
        out_ready  = 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  task automatic send_op(op_t op, logic [POS_W-1:0] pos, logic signed [VALUE_W-1:0] word,
                         logic [NEW_COUNT_W-1:0] want);
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap      = $urandom_range(1, 9);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_operation = op;
    in_position  = pos;
    in_value     = word;
    in_new_count = want;
    in_valid     = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Mostly values from a small pool so that remove finds matches.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] pool [8];
    pool = '{32'sd0, -32'sd1, 32'sd1, 32'sd7, 32'h7fffffff, 32'h80000000, 32'sd42, -32'sd42};
    if ($urandom_range(0, 9) < 7) return pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  task automatic random_op();
    int                     r;
    int unsigned            top;
    op_t                    op;
    logic [POS_W-1:0]       pos;
    logic [NEW_COUNT_W-1:0] want;
    r = $urandom_range(0, 99);
    if (r < 25)      op = OP_PUSH;
    else if (r < 40) op = OP_INSERT;
    else if (r < 48) op = OP_POP;
    else if (r < 60) op = OP_ERASE;
    else if (r < 68) op = OP_REMOVE;
    else if (r < 74) op = OP_FILL;
    else if (r < 82) op = OP_RESIZE;
    else             op = OP_READ;
    top = sb.live;
    if ($urandom_range(0, 9) < 7) pos = POS_W'($urandom_range(0, top));
    else pos = POS_W'($urandom_range(0, 255));
    r = $urandom_range(0, 19);
    if (r < 12) want = NEW_COUNT_W'($urandom_range(0, (top + 8 > CAP) ? CAP : top + 8));
    else if (r < 15) want = NEW_COUNT_W'(CAP);
    else want = NEW_COUNT_W'($urandom_range(0, 255));
    send_op(op, pos, pick_value(), want);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = '0;
    in_position  = '0;
    in_value     = '0;
    in_new_count = '0;
    idle_on      = 1'b1;
    quiet_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty list, rejected resizes, extreme values, appends past the end,
    // a full list and shrinking.
    send_op(OP_READ,   8'd0,   32'sd0,       8'd0);
    send_op(OP_POP,    8'd0,   32'sd0,       8'd0);
    send_op(OP_ERASE,  8'd0,   32'sd0,       8'd0);
    send_op(OP_REMOVE, 8'd0,   32'sd5,       8'd0);
    send_op(OP_FILL,   8'd0,   32'sd9,       8'd0);
    send_op(OP_RESIZE, 8'd0,   32'sd0,       8'd129);
    send_op(OP_RESIZE, 8'd0,   32'sd0,       8'd255);
    send_op(OP_PUSH,   8'd0,   32'h7fffffff, 8'd0);
    send_op(OP_PUSH,   8'd0,   32'h80000000, 8'd0);
    send_op(OP_INSERT, 8'd0,   -32'sd1,      8'd0);
    send_op(OP_INSERT, 8'd255, 32'sd3,       8'd0);
    send_op(OP_READ,   8'd3,   32'sd0,       8'd0);
    send_op(OP_READ,   8'd4,   32'sd0,       8'd0);
    send_op(OP_ERASE,  8'd1,   32'sd0,       8'd0);
    send_op(OP_ERASE,  8'd255, 32'sd0,       8'd0);
    send_op(OP_PUSH,   8'd0,   32'h80000000, 8'd0);
    send_op(OP_REMOVE, 8'd0,   32'h80000000, 8'd0);
    send_op(OP_RESIZE, 8'd0,   32'sd0,       8'd128);
    send_op(OP_PUSH,   8'd0,   32'sd11,      8'd0);
    send_op(OP_INSERT, 8'd5,   32'sd12,      8'd0);
    send_op(OP_READ,   8'd127, 32'sd0,       8'd0);
    send_op(OP_FILL,   8'd0,   32'h55555555, 8'd0);
    send_op(OP_ERASE,  8'd0,   32'sd0,       8'd0);
    send_op(OP_RESIZE, 8'd0,   32'sd0,       8'd3);
    send_op(OP_RESIZE, 8'd0,   32'sd0,       8'd0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // A stretch without idling mid-run, and none at all near the end.
      idle_on = !((n >= 400 && n < 480) || n >= RANDOM_ITEMS - 150);
      if (n == 300) drain_results();
      random_op();
    end
    drain_results();
    repeat (CAP + 16) @(posedge clk);

    $display("Ran %0d transactions: push %0d, pop %0d, insert %0d, erase %0d, remove %0d,",
             sb.checked, sb.op_seen[OP_PUSH], sb.op_seen[OP_POP], sb.op_seen[OP_INSERT],
             sb.op_seen[OP_ERASE], sb.op_seen[OP_REMOVE]);
    $display("fill %0d, resize %0d, read %0d; full %0d, empty %0d, too large %0d, range %0d.",
             sb.op_seen[OP_FILL], sb.op_seen[OP_RESIZE], sb.op_seen[OP_READ],
             sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_RANGE]);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("bounded_array_insert_erase_top_tb: clean");
    end else begin
      $display("bounded_array_insert_erase_top_tb: errors");
    end
    $finish;
  end

endmodule
